// ===== rtl/amae_pkg.sv =====
package amae_pkg;

    localparam int EPOCH_W = 4;

    localparam logic [3:0] ACT_RD1   = 4'd0;
    localparam logic [3:0] ACT_CWR1  = 4'd1;
    localparam logic [3:0] ACT_WR1   = 4'd2;
    localparam logic [3:0] ACT_RD2   = 4'd3;
    localparam logic [3:0] ACT_WR2   = 4'd4;
    localparam logic [3:0] ACT_RD4   = 4'd5;
    localparam logic [3:0] ACT_WR4   = 4'd6;
    localparam logic [3:0] ACT_RD8   = 4'd7;
    localparam logic [3:0] ACT_WR8   = 4'd8;
    localparam logic [3:0] ACT_ALRD  = 4'd9;
    localparam logic [3:0] ACT_ALWR  = 4'd10;
    localparam logic [3:0] ACT_BLKRD = 4'd11;
    localparam logic [3:0] ACT_BLKWR = 4'd12;

    localparam logic [31:0] RAM_BASE_RESET = 32'hA000_0000;
    localparam logic [31:0] WORD_STEP      = 32'd8;

    typedef struct packed {
        logic [3:0]  action;
        logic [31:0] mem_address;
        logic [6:0]  word_count;
        logic        chunk_start;
    } t_in_item;

    typedef struct packed {
        logic [31:0] word_address;
        logic        last_of_run;
        logic [31:0] cost_five;
        logic [31:0] cost_three;
        logic [31:0] cost_two;
        logic [31:0] byte_reads;
        logic [31:0] byte_cwrites;
    } t_out_item;

    typedef enum logic [1:0] {
        WK_READ,
        WK_RW,
        WK_WRITE
    } t_wkind;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_PUSH,
        ST_FLUSH
    } t_state;

endpackage

// ===== rtl/amae_ram.sv =====
module amae_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/aligned_memory_access_expander_core.sv =====
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_stall   i_in_item  (amae_pkg::t_in_item)
// out       output     o_out_valid / i_out_stall o_out_item (amae_pkg::t_out_item)
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_data (ram_base)
//
// One item is worked on at a time: the item is accepted, then for each word touched
// the map memory is read, the word is evaluated and written back, and each address
// produced is pushed out, and a closing step sends the last held address.
// After reset, and on every sixteenth chunk start, a clearing pass writes all
// MAP_WORDS map entries, one per cycle, before any item is worked on.
// A stalled output holds its item while the next address waits in a holding register.
module aligned_memory_access_expander_core #(
    parameter int MAP_WORDS       = 65536,
    parameter int MAX_BLOCK_WORDS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  amae_pkg::t_in_item i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output amae_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data
);

    import amae_pkg::*;

    localparam int AW = $clog2(MAP_WORDS);
    localparam int RW = EPOCH_W + 1;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_sweep, n_sweep;
    logic [EPOCH_W-1:0]  r_epoch, n_epoch;
    logic [31:0]         r_cur, n_cur;
    logic [6:0]          r_left, n_left;
    t_wkind              r_kind, n_kind;
    logic                r_trk, n_trk;
    logic [AW-1:0]       r_idx, n_idx;
    logic [1:0]          r_push, n_push;
    logic                r_held_v, n_held_v;
    logic [31:0]         r_held_addr, n_held_addr;
    logic [31:0]         r_five, n_five;
    logic [31:0]         r_three, n_three;
    logic [31:0]         r_two, n_two;
    logic [31:0]         r_brd, n_brd;
    logic [31:0]         r_bcw, n_bcw;
    logic [31:0]         r_ram_base;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out, n_out;

    logic                in_acc;
    logic                out_free;
    logic                push_step;
    logic                sweep_need;
    logic [31:0]         acc_base;
    logic [6:0]          acc_cnt;
    logic [6:0]          blk_cnt;
    t_wkind              acc_kind;
    logic                inc_five, inc_three, inc_two, inc_brd, inc_bcw;
    logic [2:0]          low;
    logic [31:0]         al;
    logic [31:0]         diff;
    logic                rd_trk;
    logic [AW-1:0]       rd_idx;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [RW-1:0]       ram_wdata;
    logic [RW-1:0]       ram_rdata;
    logic                ev_bit;
    logic [1:0]          ev_push;
    logic                ev_newbit;
    logic                out_load;
    logic                out_last;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign push_step  = !r_held_v || out_free;
    assign sweep_need = i_in_item.chunk_start && (r_epoch == {EPOCH_W{1'b1}});

    assign low     = i_in_item.mem_address[2:0];
    assign al      = {i_in_item.mem_address[31:3], 3'b000};
    assign blk_cnt = (i_in_item.word_count > 7'(MAX_BLOCK_WORDS)) ?
                     7'(MAX_BLOCK_WORDS) : i_in_item.word_count;

    always_comb begin
        acc_base  = al;
        acc_cnt   = 7'd1;
        acc_kind  = WK_READ;
        inc_five  = 1'b0;
        inc_three = 1'b0;
        inc_two   = 1'b0;
        inc_brd   = 1'b0;
        inc_bcw   = 1'b0;
        unique case (i_in_item.action)
            ACT_RD1: begin
                inc_brd = 1'b1;
            end
            ACT_CWR1: begin
                acc_kind = WK_RW;
                inc_bcw  = 1'b1;
            end
            ACT_WR1: begin
                acc_kind  = WK_RW;
                inc_three = 1'b1;
            end
            ACT_RD2: begin
                acc_cnt   = (low > 3'd6) ? 7'd2 : 7'd1;
                inc_three = (low > 3'd6);
                inc_two   = !(low > 3'd6);
            end
            ACT_WR2: begin
                acc_kind  = WK_RW;
                acc_cnt   = (low > 3'd6) ? 7'd2 : 7'd1;
                inc_five  = (low > 3'd6);
                inc_three = !(low > 3'd6);
            end
            ACT_RD4: begin
                acc_cnt   = (low > 3'd4) ? 7'd2 : 7'd1;
                inc_three = (low > 3'd4);
                inc_two   = !(low > 3'd4);
            end
            ACT_WR4: begin
                acc_kind  = WK_RW;
                acc_cnt   = (low > 3'd4) ? 7'd2 : 7'd1;
                inc_five  = (low > 3'd4);
                inc_three = !(low > 3'd4);
            end
            ACT_RD8: begin
                acc_cnt   = (low != 3'd0) ? 7'd2 : 7'd1;
                inc_three = (low != 3'd0);
            end
            ACT_WR8: begin
                acc_kind = (low == 3'd0) ? WK_WRITE : WK_RW;
                acc_cnt  = (low == 3'd0) ? 7'd1 : 7'd2;
                inc_five = (low != 3'd0);
            end
            ACT_ALRD: begin
                acc_base = i_in_item.mem_address;
            end
            ACT_ALWR: begin
                acc_base = i_in_item.mem_address;
                acc_kind = WK_WRITE;
            end
            ACT_BLKRD: begin
                acc_base = i_in_item.mem_address;
                acc_cnt  = blk_cnt;
            end
            ACT_BLKWR: begin
                acc_base = i_in_item.mem_address;
                acc_cnt  = blk_cnt;
                acc_kind = WK_WRITE;
            end
            default: begin
                acc_cnt = 7'd0;
            end
        endcase
    end

    assign diff   = r_cur - r_ram_base;
    assign rd_trk = (r_cur >= r_ram_base) && ({1'b0, diff[31:3]} < 30'(MAP_WORDS));
    assign rd_idx = diff[AW+2:3];

    assign ev_bit = r_trk && ram_rdata[0] && (ram_rdata[RW-1:1] == r_epoch);

    always_comb begin
        unique case (r_kind)
            WK_READ: begin
                ev_push   = ev_bit ? 2'd0 : 2'd1;
                ev_newbit = !ev_bit;
            end
            WK_RW: begin
                ev_push   = ev_bit ? 2'd1 : 2'd2;
                ev_newbit = 1'b1;
            end
            default: begin
                ev_push   = 2'd1;
                ev_newbit = 1'b1;
            end
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = {r_epoch, ev_newbit};
        if (r_state == ST_SWEEP) begin
            ram_we    = 1'b1;
            ram_waddr = r_sweep;
            ram_wdata = {r_epoch, 1'b0};
        end else if (r_state == ST_EVAL) begin
            ram_we = r_trk;
        end
    end

    amae_ram #(
        .WIDTH (RW),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (rd_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_SWEEP: begin
                if (r_sweep == AW'(MAP_WORDS - 1)) begin
                    n_state = (r_left != 7'd0) ? ST_READ : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    if (sweep_need) begin
                        n_state = ST_SWEEP;
                    end else if (acc_cnt != 7'd0) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (ev_push != 2'd0) begin
                    n_state = ST_PUSH;
                end else begin
                    n_state = (r_left == 7'd1) ? ST_FLUSH : ST_READ;
                end
            end
            ST_PUSH: begin
                if (push_step && r_push == 2'd1) begin
                    n_state = (r_left == 7'd1) ? ST_FLUSH : ST_READ;
                end
            end
            ST_FLUSH: begin
                if (!r_held_v || out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_sweep     = r_sweep;
        n_epoch     = r_epoch;
        n_cur       = r_cur;
        n_left      = r_left;
        n_kind      = r_kind;
        n_trk       = r_trk;
        n_idx       = r_idx;
        n_push      = r_push;
        n_held_v    = r_held_v;
        n_held_addr = r_held_addr;
        n_five      = r_five;
        n_three     = r_three;
        n_two       = r_two;
        n_brd       = r_brd;
        n_bcw       = r_bcw;
        out_load    = 1'b0;
        out_last    = 1'b0;
        unique case (r_state)
            ST_SWEEP: begin
                n_sweep = r_sweep + AW'(1);
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_cur   = acc_base;
                    n_left  = acc_cnt;
                    n_kind  = acc_kind;
                    n_five  = (i_in_item.chunk_start ? 32'd0 : r_five)  + 32'(inc_five);
                    n_three = (i_in_item.chunk_start ? 32'd0 : r_three) + 32'(inc_three);
                    n_two   = (i_in_item.chunk_start ? 32'd0 : r_two)   + 32'(inc_two);
                    n_brd   = (i_in_item.chunk_start ? 32'd0 : r_brd)   + 32'(inc_brd);
                    n_bcw   = (i_in_item.chunk_start ? 32'd0 : r_bcw)   + 32'(inc_bcw);
                    if (i_in_item.chunk_start) begin
                        n_epoch = r_epoch + EPOCH_W'(1);
                        n_sweep = '0;
                    end
                end
            end
            ST_READ: begin
                n_trk = rd_trk;
                n_idx = rd_idx;
            end
            ST_EVAL: begin
                n_push = ev_push;
                if (ev_push == 2'd0) begin
                    n_cur  = r_cur + WORD_STEP;
                    n_left = r_left - 7'd1;
                end
            end
            ST_PUSH: begin
                if (push_step) begin
                    n_push      = r_push - 2'd1;
                    n_held_v    = 1'b1;
                    n_held_addr = r_cur;
                    out_load    = r_held_v;
                    if (r_push == 2'd1) begin
                        n_cur  = r_cur + WORD_STEP;
                        n_left = r_left - 7'd1;
                    end
                end
            end
            ST_FLUSH: begin
                if (r_held_v && out_free) begin
                    out_load = 1'b1;
                    out_last = 1'b1;
                    n_held_v = 1'b0;
                end
            end
            default: begin
                n_push = r_push;
            end
        endcase
    end

    always_comb begin
        n_out = r_out;
        if (out_load) begin
            n_out.word_address = r_held_addr;
            n_out.last_of_run  = out_last;
            n_out.cost_five    = r_five;
            n_out.cost_three   = r_three;
            n_out.cost_two     = r_two;
            n_out.byte_reads   = r_brd;
            n_out.byte_cwrites = r_bcw;
        end
        n_out_valid = out_load || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_sweep     <= '0;
            r_epoch     <= '0;
            r_left      <= '0;
            r_push      <= '0;
            r_held_v    <= 1'b0;
            r_five      <= '0;
            r_three     <= '0;
            r_two       <= '0;
            r_brd       <= '0;
            r_bcw       <= '0;
            r_ram_base  <= RAM_BASE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_epoch     <= n_epoch;
            r_left      <= n_left;
            r_push      <= n_push;
            r_held_v    <= n_held_v;
            r_five      <= n_five;
            r_three     <= n_three;
            r_two       <= n_two;
            r_brd       <= n_brd;
            r_bcw       <= n_bcw;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_ram_base <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur       <= n_cur;
        r_kind      <= n_kind;
        r_trk       <= n_trk;
        r_idx       <= n_idx;
        r_held_addr <= n_held_addr;
        r_out       <= n_out;
    end

    a_idle_nothing_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> !r_held_v)
        else $error("held address left over while idle");

    a_no_write_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_READ |-> !ram_we)
        else $error("map written in the read cycle");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_PUSH |-> r_push != 2'd0)
        else $error("push state without pending addresses");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten while stalled");

    a_words_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ || r_state == ST_EVAL || r_state == ST_PUSH) |-> r_left != 7'd0)
        else $error("word loop running with no words left");

endmodule

// ===== verif/tb_aligned_memory_access_expander_core.sv =====
`timescale 1ns / 100ps

module tb_aligned_memory_access_expander_core;
    import amae_pkg::*;

    localparam int MAP_WORDS       = 65536;
    localparam int MAX_BLOCK_WORDS = 64;
    localparam int IDLE_LIMIT      = 200000;
    localparam int SETTLE_CYCLES   = 400;
    localparam int LONG_HOLD       = 500;
    localparam int PHASE_ITEMS     = 30;
    localparam int NUM_PHASES      = 5;

    localparam logic [3:0]  ACT_NONE_FIRST = 4'd13;
    localparam logic [3:0]  ACT_NONE_LAST  = 4'd15;
    localparam logic [31:0] MAP_SPAN       = 32'(MAP_WORDS * 8);

    class word_step_tracker;
        logic [31:0] ram_base;
        bit          pending_map[0:MAP_WORDS-1];
        logic [31:0] five_cnt;
        logic [31:0] three_cnt;
        logic [31:0] two_cnt;
        logic [31:0] byte_rd_cnt;
        logic [31:0] byte_cwr_cnt;
        logic [31:0] step_addrs[$];
        t_out_item   pending_steps[$];
        int          errors;

        function new();
            ram_base = RAM_BASE_RESET;
            errors   = 0;
            clear_chunk();
        endfunction

        function void clear_chunk();
            foreach (pending_map[i]) pending_map[i] = 1'b0;
            five_cnt     = '0;
            three_cnt    = '0;
            two_cnt      = '0;
            byte_rd_cnt  = '0;
            byte_cwr_cnt = '0;
        endfunction

        function void add_step(logic [31:0] w);
            step_addrs = {step_addrs, w};
        endfunction

        // Returns the map offset of a tracked word, or -1 when the word is not tracked.
        function int map_slot(logic [31:0] w);
            logic [31:0] ofs;
            if (w < ram_base) return -1;
            ofs = (w - ram_base) >> 3;
            if (ofs >= MAP_WORDS) return -1;
            return int'(ofs);
        endfunction

        function void read_word(logic [31:0] w);
            int slot;
            slot = map_slot(w);
            if (slot < 0) begin
                add_step(w);
            end else if (pending_map[slot]) begin
                pending_map[slot] = 1'b0;
            end else begin
                pending_map[slot] = 1'b1;
                add_step(w);
            end
        endfunction

        function void rw_word(logic [31:0] w);
            int slot;
            slot = map_slot(w);
            if (slot < 0) begin
                add_step(w);
                add_step(w);
            end else begin
                if (!pending_map[slot]) add_step(w);
                add_step(w);
                pending_map[slot] = 1'b1;
            end
        endfunction

        function void write_word(logic [31:0] w);
            int slot;
            slot = map_slot(w);
            if (slot >= 0) pending_map[slot] = 1'b1;
            add_step(w);
        endfunction

        function void note_access(t_in_item it);
            logic [31:0] addr;
            logic [31:0] al;
            logic [2:0]  low;
            int          count;
            t_out_item   r;
            step_addrs.delete();
            if (it.chunk_start) clear_chunk();
            addr  = it.mem_address;
            al    = {addr[31:3], 3'b000};
            low   = addr[2:0];
            count = (it.word_count > MAX_BLOCK_WORDS) ? MAX_BLOCK_WORDS : int'(it.word_count);
            case (it.action)
                ACT_RD1: begin
                    byte_rd_cnt++;
                    read_word(al);
                end
                ACT_CWR1: begin
                    byte_cwr_cnt++;
                    rw_word(al);
                end
                ACT_WR1: begin
                    three_cnt++;
                    rw_word(al);
                end
                ACT_RD2: begin
                    read_word(al);
                    if (low > 6) begin
                        read_word(al + WORD_STEP);
                        three_cnt++;
                    end else begin
                        two_cnt++;
                    end
                end
                ACT_WR2: begin
                    rw_word(al);
                    if (low > 6) begin
                        rw_word(al + WORD_STEP);
                        five_cnt++;
                    end else begin
                        three_cnt++;
                    end
                end
                ACT_RD4: begin
                    read_word(al);
                    if (low > 4) begin
                        three_cnt++;
                        read_word(al + WORD_STEP);
                    end else begin
                        two_cnt++;
                    end
                end
                ACT_WR4: begin
                    rw_word(al);
                    if (low > 4) begin
                        five_cnt++;
                        rw_word(al + WORD_STEP);
                    end else begin
                        three_cnt++;
                    end
                end
                ACT_RD8: begin
                    read_word(al);
                    if (low > 0) begin
                        three_cnt++;
                        read_word(al + WORD_STEP);
                    end
                end
                ACT_WR8: begin
                    if (low == 0) begin
                        write_word(al);
                    end else begin
                        five_cnt++;
                        rw_word(al);
                        rw_word(al + WORD_STEP);
                    end
                end
                ACT_ALRD: read_word(addr);
                ACT_ALWR: write_word(addr);
                ACT_BLKRD: begin
                    for (int i = 0; i < count; i++) read_word(addr + WORD_STEP * 32'(i));
                end
                ACT_BLKWR: begin
                    for (int i = 0; i < count; i++) write_word(addr + WORD_STEP * 32'(i));
                end
                default: ;
            endcase
            foreach (step_addrs[k]) begin
                r.word_address = step_addrs[k];
                r.last_of_run  = (k == step_addrs.size() - 1);
                r.cost_five    = five_cnt;
                r.cost_three   = three_cnt;
                r.cost_two     = two_cnt;
                r.byte_reads   = byte_rd_cnt;
                r.byte_cwrites = byte_cwr_cnt;
                pending_steps = {pending_steps, r};
            end
        endfunction

        task report(string what);
            errors++;
            $display("mismatch: %s", what);
        endtask

        task check_step(t_out_item got);
            t_out_item want;
            if (pending_steps.size() == 0) begin
                report($sformatf("unexpected item at address %h", got.word_address));
                return;
            end
            want = pending_steps.pop_front();
            if (got.word_address !== want.word_address)
                report($sformatf("word_address %h, expected %h",
                                 got.word_address, want.word_address));
            if (got.last_of_run !== want.last_of_run)
                report($sformatf("last_of_run %b, expected %b at %h",
                                 got.last_of_run, want.last_of_run, want.word_address));
            if (got.cost_five !== want.cost_five)
                report($sformatf("cost_five %h, expected %h", got.cost_five, want.cost_five));
            if (got.cost_three !== want.cost_three)
                report($sformatf("cost_three %h, expected %h", got.cost_three, want.cost_three));
            if (got.cost_two !== want.cost_two)
                report($sformatf("cost_two %h, expected %h", got.cost_two, want.cost_two));
            if (got.byte_reads !== want.byte_reads)
                report($sformatf("byte_reads %h, expected %h", got.byte_reads, want.byte_reads));
            if (got.byte_cwrites !== want.byte_cwrites)
                report($sformatf("byte_cwrites %h, expected %h",
                                 got.byte_cwrites, want.byte_cwrites));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in_item    in_item;
    logic        out_valid;
    logic        out_stall;
    t_out_item   out_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    word_step_tracker steps;
    bit long_hold_req = 1'b0;
    int in_quiet      = 0;
    int out_quiet     = 0;
    int idle_cycles   = 0;

    aligned_memory_access_expander_core #(
        .MAP_WORDS      (MAP_WORDS),
        .MAX_BLOCK_WORDS(MAX_BLOCK_WORDS)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) steps.check_step(out_item);
    end

    // Quiet stretches give runs of back-to-back items between random waits.
    task automatic draw_gap(inout int quiet, output int gap);
        if (quiet > 0) begin
            quiet--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 17);
            if ($urandom_range(0, 11) == 0) quiet = $urandom_range(8, 40);
        end
    endtask

    initial begin : out_side
        int gap;
        do @(negedge clk); while (!rst_n);
        forever begin
            draw_gap(out_quiet, gap);
            if (long_hold_req) begin
                gap = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    task automatic send_item(t_in_item it);
        int gap;
        draw_gap(in_quiet, gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        steps.note_access(it);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (steps.pending_steps.size() != 0);
    endtask

    // An item may leave no result at all, so the block must also be back at rest.
    task automatic write_ram_base(logic [31:0] value);
        wait_drained();
        while (in_stall) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        steps.ram_base = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic t_in_item make_item(logic [3:0] act, logic [31:0] addr, int cnt, bit cs);
        t_in_item it;
        it.action      = act;
        it.mem_address = addr;
        it.word_count  = 7'(cnt);
        it.chunk_start = cs;
        return it;
    endfunction

    // Most addresses fall on a small set of tracked words so that words are revisited.
    function automatic t_in_item random_item();
        t_in_item    it;
        logic [31:0] base;
        base = steps.ram_base;
        if ($urandom_range(0, 19) == 0)
            it.action = 4'($urandom_range(ACT_NONE_FIRST, ACT_NONE_LAST));
        else
            it.action = 4'($urandom_range(ACT_RD1, ACT_BLKWR));
        case ($urandom_range(0, 9))
            6: it.mem_address = base + MAP_SPAN - 32'd24 + 32'($urandom_range(0, 47));
            7: it.mem_address = base - 32'($urandom_range(1, 64));
            8: it.mem_address = 32'hFFFF_FFFF - 32'($urandom_range(0, 31));
            9: it.mem_address = $urandom();
            default: it.mem_address = base + 32'($urandom_range(0, 15) * 8)
                                      + 32'($urandom_range(0, 7));
        endcase
        case ($urandom_range(0, 15))
            0: it.word_count = 7'd0;
            1: it.word_count = 7'(MAX_BLOCK_WORDS);
            2: it.word_count = 7'($urandom_range(MAX_BLOCK_WORDS + 1, 127));
            default: it.word_count = 7'($urandom_range(1, 6));
        endcase
        it.chunk_start = ($urandom_range(0, 14) == 0);
        return it;
    endfunction

    task automatic run_directed();
        logic [31:0] b;
        b = RAM_BASE_RESET;
        send_item(make_item(ACT_RD1, b + 32'd3, 0, 1'b1));
        send_item(make_item(ACT_RD1, b + 32'd5, 0, 1'b0));
        send_item(make_item(ACT_CWR1, b + 32'd1, 0, 1'b0));
        send_item(make_item(ACT_WR1, b + 32'd16, 0, 1'b0));
        send_item(make_item(ACT_RD2, b + 32'd23, 0, 1'b0));
        send_item(make_item(ACT_RD2, 32'h0000_1000, 0, 1'b0));
        send_item(make_item(ACT_WR2, b + 32'h2F, 0, 1'b0));
        send_item(make_item(ACT_WR2, 32'h0000_0002, 0, 1'b0));
        send_item(make_item(ACT_RD4, b + 32'h45, 0, 1'b0));
        send_item(make_item(ACT_RD4, b + 32'h44, 0, 1'b0));
        send_item(make_item(ACT_WR4, 32'hFFFF_FFFD, 0, 1'b0));
        send_item(make_item(ACT_WR4, b + 32'h100, 0, 1'b0));
        send_item(make_item(ACT_RD8, b + 32'h200, 0, 1'b0));
        send_item(make_item(ACT_RD8, 32'hFFFF_FFFF, 0, 1'b0));
        send_item(make_item(ACT_WR8, b + 32'h300, 0, 1'b0));
        send_item(make_item(ACT_WR8, b + 32'h301, 0, 1'b0));
        send_item(make_item(ACT_ALRD, b + 32'h203, 0, 1'b0));
        send_item(make_item(ACT_ALWR, 32'h1234_5677, 0, 1'b0));
        send_item(make_item(ACT_BLKRD, b + 32'h200, 3, 1'b0));
        send_item(make_item(ACT_BLKWR, b + MAP_SPAN - 32'd16, 4, 1'b0));
        send_item(make_item(ACT_BLKRD, b, 0, 1'b0));
        send_item(make_item(ACT_BLKWR, 32'hFFFF_FF00, 127, 1'b0));
        send_item(make_item(ACT_NONE_FIRST, b, 127, 1'b1));
        send_item(make_item(ACT_NONE_LAST, 32'hFFFF_FFFF, 0, 1'b0));
        send_item(make_item(ACT_BLKRD, b, MAX_BLOCK_WORDS, 1'b1));
        send_item(make_item(ACT_RD1, b + 32'h200, 0, 1'b0));
    endtask

    initial begin : stimulus
        logic [31:0] phase_bases[NUM_PHASES];
        steps     = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        phase_bases[0] = 32'h0000_0000;
        phase_bases[1] = 32'hFFFF_FFFF;
        phase_bases[2] = 32'hFFF8_0000;
        phase_bases[3] = $urandom();
        phase_bases[4] = RAM_BASE_RESET;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        run_directed();
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_ram_base(phase_bases[p]);
            if (p == 1) long_hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 2 && n == PHASE_ITEMS / 2) wait_drained();
                send_item(random_item());
            end
        end
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (steps.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
